// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion helpers shared by the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on a clock, masked while reset is low
`define A_SYNC(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// condition that must never be seen
`define A_NEVER(lbl, clk, rst_n, cond) `A_SYNC(lbl, clk, rst_n, !(cond))

`endif

// ===== design/rtnf_pkg.sv =====
// ----------------------------------------------------------------------------
// rtnf_pkg
// types, constants and helpers for the ray / triangle nearest-farthest unit
// ----------------------------------------------------------------------------
package rtnf_pkg;

    localparam int DATA_W            = 32;
    localparam int IDX_OUT_W         = 12;
    localparam int EPS_W             = 17;
    localparam int ACC_W             = 64;
    localparam int MAC_STEPS         = 24;
    localparam int STEP_W            = 5;
    localparam int ADDR_W            = 5;
    localparam int MAX_TRIANGLES_DEF = 4096;
    localparam int FRAC_BITS_DEF     = 16;

    typedef logic [2:0] t_reg_idx;
    localparam t_reg_idx REG_ORG_X = 3'd0;
    localparam t_reg_idx REG_ORG_Y = 3'd1;
    localparam t_reg_idx REG_ORG_Z = 3'd2;
    localparam t_reg_idx REG_DIR_X = 3'd3;
    localparam t_reg_idx REG_DIR_Y = 3'd4;
    localparam t_reg_idx REG_DIR_Z = 3'd5;
    localparam t_reg_idx REG_EPS   = 3'd6;

    typedef enum logic [2:0] {
        V_DIR, V_E1, V_E2, V_TV, V_P, V_Q
    } t_vsel;

    typedef enum logic [2:0] {
        D_P, D_DET, D_Q, D_UN, D_VN, D_TN
    } t_dst;

    typedef struct packed {
        t_vsel      a_sel;
        logic [1:0] a_idx;
        t_vsel      b_sel;
        logic [1:0] b_idx;
        t_dst       dst;
        logic [1:0] comp;
        logic       first;
    } t_mac_op;

    typedef struct packed {
        logic signed [DATA_W-1:0] a_x;
        logic signed [DATA_W-1:0] a_y;
        logic signed [DATA_W-1:0] a_z;
        logic signed [DATA_W-1:0] b_x;
        logic signed [DATA_W-1:0] b_y;
        logic signed [DATA_W-1:0] b_z;
        logic signed [DATA_W-1:0] c_x;
        logic signed [DATA_W-1:0] c_y;
        logic signed [DATA_W-1:0] c_z;
        logic                     last_triangle;
    } t_tri;

    typedef struct packed {
        logic                     any_hit;
        logic [IDX_OUT_W-1:0]     near_index;
        logic signed [DATA_W-1:0] near_t;
        logic [IDX_OUT_W-1:0]     far_index;
        logic signed [DATA_W-1:0] far_t;
    } t_res;

    typedef struct packed {
        logic signed [DATA_W-1:0] org_x;
        logic signed [DATA_W-1:0] org_y;
        logic signed [DATA_W-1:0] org_z;
        logic signed [DATA_W-1:0] dir_x;
        logic signed [DATA_W-1:0] dir_y;
        logic signed [DATA_W-1:0] dir_z;
        logic [EPS_W-1:0]         eps;
    } t_cfg;

    typedef struct packed {
        logic              load;
        logic              mac_en;
        logic [STEP_W-1:0] step;
        logic              chk;
        logic              div_en;
        logic              upd;
    } t_cmd;

    typedef struct packed {
        logic last;
        logic hit_ok;
    } t_sts;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = 64'sh0000_0000_7FFF_FFFF;
        lo = -64'sh0000_0000_8000_0000;
        if (v > hi) begin
            return 32'sh7FFF_FFFF;
        end else if (v < lo) begin
            return 32'sh8000_0000;
        end
        return v[DATA_W-1:0];
    endfunction

    // small wrap into 0..2
    function automatic logic [1:0] wrap3(input logic [2:0] v);
        return (v >= 3'd3) ? 2'(v - 3'd3) : v[1:0];
    endfunction

    // operand schedule of the shared multiplier
    function automatic t_mac_op mac_op(input logic [STEP_W-1:0] step);
        t_mac_op           op;
        logic [STEP_W-1:0] j;
        logic [1:0]        c;
        logic              sec;
        logic              is_cross;
        op = '{a_sel: V_DIR, a_idx: 2'd0, b_sel: V_DIR, b_idx: 2'd0,
               dst: D_P, comp: 2'd0, first: 1'b0};
        is_cross = 1'b0;
        j = step;
        if (step < 5'd6) begin
            is_cross = 1'b1; op.a_sel = V_DIR; op.b_sel = V_E2; op.dst = D_P;
        end else if (step < 5'd9) begin
            j = step - 5'd6; op.a_sel = V_E1; op.b_sel = V_P; op.dst = D_DET;
        end else if (step < 5'd15) begin
            is_cross = 1'b1; j = step - 5'd9;
            op.a_sel = V_TV; op.b_sel = V_E1; op.dst = D_Q;
        end else if (step < 5'd18) begin
            j = step - 5'd15; op.a_sel = V_TV; op.b_sel = V_P; op.dst = D_UN;
        end else if (step < 5'd21) begin
            j = step - 5'd18; op.a_sel = V_DIR; op.b_sel = V_Q; op.dst = D_VN;
        end else begin
            j = step - 5'd21; op.a_sel = V_E2; op.b_sel = V_Q; op.dst = D_TN;
        end
        if (is_cross) begin
            c   = j[2:1];
            sec = j[0];
            op.a_idx = wrap3(3'(c) + 3'd1 + 3'(sec));
            op.b_idx = wrap3(3'(c) + 3'd2 - 3'(sec));
            op.comp  = c;
            op.first = !sec;
        end else begin
            op.a_idx = j[1:0];
            op.b_idx = j[1:0];
            op.comp  = j[1:0];
            op.first = (j[1:0] == 2'd0);
        end
        return op;
    endfunction

endpackage

// ===== design/rtnf_if.sv =====
// ----------------------------------------------------------------------------
// rtnf_tri_if / rtnf_res_if
// valid-ready channels for triangle beats and result beats
// ----------------------------------------------------------------------------
interface rtnf_tri_if;
    logic             valid;
    logic             ready;
    rtnf_pkg::t_tri   payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface rtnf_res_if;
    logic             valid;
    logic             ready;
    rtnf_pkg::t_res   payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== design/rtnf_ctrl.sv =====
// ----------------------------------------------------------------------------
// rtnf_ctrl
// sequencer: accept, multiply schedule, hit check, divide, track update
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rtnf_ctrl #(
    parameter int FRAC_BITS = rtnf_pkg::FRAC_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  rtnf_pkg::t_sts  i_sts,
    output rtnf_pkg::t_cmd  o_cmd
);

    localparam int DIV_LEN = rtnf_pkg::ACC_W + FRAC_BITS;
    localparam int DIV_W   = $clog2(DIV_LEN);
    localparam logic [DIV_W-1:0] DIV_LAST = DIV_W'(DIV_LEN - 1);
    localparam logic [rtnf_pkg::STEP_W-1:0] STEP_END = rtnf_pkg::STEP_W'(rtnf_pkg::MAC_STEPS);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MAC  = 5'b00010,
        S_CHK  = 5'b00100,
        S_DIV  = 5'b01000,
        S_UPD  = 5'b10000
    } t_state;

    t_state                      r_state, n_state;
    logic [rtnf_pkg::STEP_W-1:0] r_step, n_step;
    logic [DIV_W-1:0]            r_div, n_div;
    logic                        r_out_valid, n_out_valid;
    logic                        w_go;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    // a result may only be written once the output register is free
    assign w_go = !(i_sts.last && r_out_valid && !i_out_ready);

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_div       = r_div;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_step     = '0;
                    n_state    = S_MAC;
                end
            end
            S_MAC: begin
                o_cmd.step = r_step;
                if (r_step == STEP_END) begin
                    n_state = S_CHK;
                end else begin
                    o_cmd.mac_en = 1'b1;
                    n_step       = r_step + 1'b1;
                end
            end
            S_CHK: begin
                o_cmd.chk = 1'b1;
                n_div     = '0;
                n_state   = i_sts.hit_ok ? S_DIV : S_UPD;
            end
            S_DIV: begin
                o_cmd.div_en = 1'b1;
                n_div        = r_div + 1'b1;
                if (r_div == DIV_LAST) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                if (w_go) begin
                    o_cmd.upd = 1'b1;
                    n_state   = S_IDLE;
                    if (i_sts.last) begin
                        n_out_valid = 1'b1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_div       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_div       <= n_div;
            r_out_valid <= n_out_valid;
        end
    end

    `A_SYNC(a_accept_starts_mac, i_clk, i_rst_n, (i_in_valid && o_in_ready) |=> (r_state == S_MAC))
    `A_SYNC(a_div_ends, i_clk, i_rst_n, (r_state == S_DIV && r_div == DIV_LAST) |=> (r_state == S_UPD))
    `A_SYNC(a_last_gives_result, i_clk, i_rst_n, (o_cmd.upd && i_sts.last) |=> r_out_valid)

endmodule

// ===== design/rtnf_dp.sv =====
// ----------------------------------------------------------------------------
// rtnf_dp
// edges, shared multiplier with accumulators, hit test, serial divider,
// nearest / farthest tracking and result register
// ----------------------------------------------------------------------------
module rtnf_dp #(
    parameter int MAX_TRIANGLES = rtnf_pkg::MAX_TRIANGLES_DEF,
    parameter int FRAC_BITS     = rtnf_pkg::FRAC_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  rtnf_pkg::t_cfg  i_cfg,
    input  rtnf_pkg::t_tri  i_tri,
    input  rtnf_pkg::t_cmd  i_cmd,
    output rtnf_pkg::t_sts  o_sts,
    output rtnf_pkg::t_res  o_res
);

    localparam int DW     = rtnf_pkg::DATA_W;
    localparam int AW     = rtnf_pkg::ACC_W;
    localparam int IDX_W  = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
    localparam int NW     = AW + FRAC_BITS;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_TRIANGLES - 1);

    logic signed [DW-1:0] w_dir[3], w_org[3], w_a[3], w_b[3], w_c[3];
    logic signed [DW-1:0] r_e1[3], r_e2[3], r_tv[3], r_p[3], r_q[3];
    logic signed [AW-1:0] r_tmp, r_det, r_un, r_vn, r_tn;
    logic signed [AW-1:0] r_prod;
    logic                 r_cvalid;
    rtnf_pkg::t_mac_op    r_cop, w_op;
    logic signed [DW-1:0] w_opa, w_opb;
    logic signed [AW-1:0] w_pq;
    logic                 r_last;

    assign w_dir = '{i_cfg.dir_x, i_cfg.dir_y, i_cfg.dir_z};
    assign w_org = '{i_cfg.org_x, i_cfg.org_y, i_cfg.org_z};
    assign w_a   = '{i_tri.a_x, i_tri.a_y, i_tri.a_z};
    assign w_b   = '{i_tri.b_x, i_tri.b_y, i_tri.b_z};
    assign w_c   = '{i_tri.c_x, i_tri.c_y, i_tri.c_z};

    function automatic logic signed [DW-1:0] pick(
        input rtnf_pkg::t_vsel sel, input logic [1:0] idx,
        input logic signed [DW-1:0] dir[3], input logic signed [DW-1:0] e1[3],
        input logic signed [DW-1:0] e2[3], input logic signed [DW-1:0] tv[3],
        input logic signed [DW-1:0] p[3], input logic signed [DW-1:0] q[3]);
        logic signed [DW-1:0] v[3];
        case (sel)
            rtnf_pkg::V_DIR: v = dir;
            rtnf_pkg::V_E1:  v = e1;
            rtnf_pkg::V_E2:  v = e2;
            rtnf_pkg::V_TV:  v = tv;
            rtnf_pkg::V_P:   v = p;
            rtnf_pkg::V_Q:   v = q;
            default:         v = dir;
        endcase
        return (idx == 2'd3) ? '0 : v[idx];
    endfunction

    assign w_op  = rtnf_pkg::mac_op(i_cmd.step);
    assign w_opa = pick(w_op.a_sel, w_op.a_idx, w_dir, r_e1, r_e2, r_tv, r_p, r_q);
    assign w_opb = pick(w_op.b_sel, w_op.b_idx, w_dir, r_e1, r_e2, r_tv, r_p, r_q);
    // floor shift of the registered product
    assign w_pq  = r_prod >>> FRAC_BITS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cvalid <= 1'b0;
        end else begin
            r_cvalid <= i_cmd.mac_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int i = 0; i < 3; i++) begin
                r_e1[i] <= rtnf_pkg::sat32(AW'(w_b[i]) - AW'(w_a[i]));
                r_e2[i] <= rtnf_pkg::sat32(AW'(w_c[i]) - AW'(w_a[i]));
                r_tv[i] <= rtnf_pkg::sat32(AW'(w_org[i]) - AW'(w_a[i]));
            end
            r_last <= i_tri.last_triangle;
        end
        if (i_cmd.mac_en) begin
            r_prod <= AW'(w_opa) * AW'(w_opb);
            r_cop  <= w_op;
        end
        if (r_cvalid) begin
            case (r_cop.dst)
                rtnf_pkg::D_P, rtnf_pkg::D_Q: begin
                    if (r_cop.first) begin
                        r_tmp <= w_pq;
                    end else if (r_cop.dst == rtnf_pkg::D_P) begin
                        r_p[r_cop.comp] <= rtnf_pkg::sat32(r_tmp - w_pq);
                    end else begin
                        r_q[r_cop.comp] <= rtnf_pkg::sat32(r_tmp - w_pq);
                    end
                end
                rtnf_pkg::D_DET: r_det <= r_cop.first ? w_pq : r_det + w_pq;
                rtnf_pkg::D_UN:  r_un  <= r_cop.first ? w_pq : r_un + w_pq;
                rtnf_pkg::D_VN:  r_vn  <= r_cop.first ? w_pq : r_vn + w_pq;
                rtnf_pkg::D_TN:  r_tn  <= r_cop.first ? w_pq : r_tn + w_pq;
                default: ;
            endcase
        end
    end

    // hit test on the finished sums
    logic signed [AW-1:0] w_eps, w_uv;
    logic                 w_det_ok, w_in;
    assign w_eps = AW'(i_cfg.eps);
    assign w_uv  = r_un + r_vn;
    assign w_det_ok = (r_det != '0) && !((r_det > -w_eps) && (r_det < w_eps));
    always_comb begin
        if (r_det > 0) begin
            w_in = !(r_un < 0 || r_un > r_det || r_vn < 0 || w_uv > r_det);
        end else begin
            w_in = !(r_un > 0 || r_un < r_det || r_vn > 0 || w_uv < r_det);
        end
    end
    assign o_sts.hit_ok = w_det_ok && w_in;
    assign o_sts.last   = r_last;

    // restoring divider, one quotient bit per cycle
    logic [NW-1:0]   r_num;
    logic [AW-1:0]   r_rem, r_den;
    logic [DW:0]     r_quo;
    logic            r_ovf, r_neg, r_hit;
    logic [AW:0]     w_rsh, w_rsub;
    logic            w_qb;
    assign w_rsh  = {r_rem, r_num[NW-1]};
    assign w_rsub = w_rsh - {1'b0, r_den};
    assign w_qb   = (w_rsh >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (i_cmd.chk) begin
            r_hit <= o_sts.hit_ok;
            r_neg <= r_tn[AW-1] ^ r_det[AW-1];
            r_num <= {(r_tn[AW-1] ? AW'(-r_tn) : AW'(r_tn)), FRAC_BITS'(0)};
            r_den <= r_det[AW-1] ? AW'(-r_det) : AW'(r_det);
            r_rem <= '0;
            r_quo <= '0;
            r_ovf <= 1'b0;
        end else if (i_cmd.div_en) begin
            r_num <= {r_num[NW-2:0], 1'b0};
            r_rem <= w_qb ? w_rsub[AW-1:0] : w_rsh[AW-1:0];
            r_quo <= {r_quo[DW-1:0], w_qb};
            r_ovf <= r_ovf | r_quo[DW];
        end
    end

    logic [DW:0]          w_lim;
    logic [DW-1:0]        w_mag;
    logic signed [DW-1:0] w_t;
    assign w_lim = r_neg ? (DW+1)'(33'h0_8000_0000) : (DW+1)'(33'h0_7FFF_FFFF);
    assign w_mag = (r_ovf || (r_quo > w_lim)) ? w_lim[DW-1:0] : r_quo[DW-1:0];
    assign w_t   = r_neg ? -$signed(w_mag) : $signed(w_mag);

    // tracking of nearest and farthest
    logic [IDX_W-1:0]     r_cnt;
    logic                 r_seen, n_seen;
    logic [IDX_W-1:0]     r_ni, r_fi, n_ni, n_fi;
    logic signed [DW-1:0] r_nt, r_ft, n_nt, n_ft;

    function automatic logic [DW:0] abs33(input logic signed [DW-1:0] v);
        return v[DW-1] ? (DW+1)'(-(DW+1)'(v)) : (DW+1)'(v);
    endfunction

    always_comb begin
        n_seen = r_seen;
        n_ni = r_ni; n_nt = r_nt;
        n_fi = r_fi; n_ft = r_ft;
        if (r_hit) begin
            if (!r_seen) begin
                n_seen = 1'b1;
                n_ni = r_cnt; n_nt = w_t;
                n_fi = r_cnt; n_ft = w_t;
            end else begin
                if ({1'b0, w_mag} < abs33(r_nt)) begin
                    n_ni = r_cnt; n_nt = w_t;
                end
                if ({1'b0, w_mag} > abs33(r_ft)) begin
                    n_fi = r_cnt; n_ft = w_t;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_seen <= 1'b0;
            r_ni   <= '0;
            r_nt   <= '0;
            r_fi   <= '0;
            r_ft   <= '0;
        end else if (i_cmd.upd) begin
            if (r_last) begin
                r_cnt  <= '0;
                r_seen <= 1'b0;
                r_ni   <= '0;
                r_nt   <= '0;
                r_fi   <= '0;
                r_ft   <= '0;
            end else begin
                r_cnt  <= (r_cnt == IDX_LAST) ? '0 : r_cnt + 1'b1;
                r_seen <= n_seen;
                r_ni   <= n_ni;
                r_nt   <= n_nt;
                r_fi   <= n_fi;
                r_ft   <= n_ft;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.upd && r_last) begin
            o_res.any_hit    <= n_seen;
            o_res.near_index <= rtnf_pkg::IDX_OUT_W'(n_ni);
            o_res.near_t     <= n_nt;
            o_res.far_index  <= rtnf_pkg::IDX_OUT_W'(n_fi);
            o_res.far_t      <= n_ft;
        end
    end

endmodule

// ===== design/ray_triangle_nearest_farthest_hit_unit.sv =====
// ----------------------------------------------------------------------------
// ray_triangle_nearest_farthest_hit_unit
// nearest and farthest ray / triangle hit over a streamed triangle list
// ----------------------------------------------------------------------------
// usage:
//   the ray origin, direction and determinant threshold must be written over
//   the apb port only while the unit is idle; the unit does not enforce this
//   (pready is tied high, reads return the register). triangles then arrive
//   as beats on i_tri, three vertices and a last flag each. o_res carries one
//   beat after each triangle marked last, with the hit flag, index and t of
//   the nearest and the farthest hit. one triangle at a time is processed:
//   an accept, the multiply schedule on the single shared 32x32 multiplier,
//   a check, the bit-serial divider when the triangle is hit, and an update.
//   the result register frees the input side: a new list is accepted while
//   the previous result waits; only the next last triangle holds in its
//   update cycle until o_res is taken.
//   a synchronous active-low reset restores the default ray (origin 0,
//   direction +y), threshold 1, and clears the tracking state and o_res.valid.
// ----------------------------------------------------------------------------
module ray_triangle_nearest_farthest_hit_unit #(
    parameter int MAX_TRIANGLES = rtnf_pkg::MAX_TRIANGLES_DEF,
    parameter int FRAC_BITS     = rtnf_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    rtnf_tri_if.sink                      i_tri,
    rtnf_res_if.source                    o_res,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rtnf_pkg::ADDR_W-1:0]   paddr,
    input  logic [rtnf_pkg::DATA_W-1:0]   pwdata,
    output logic [rtnf_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    rtnf_pkg::t_cfg    r_cfg;
    rtnf_pkg::t_cmd    w_cmd;
    rtnf_pkg::t_sts    w_sts;
    rtnf_pkg::t_reg_idx w_ridx;
    logic              w_wr;

    assign pready = 1'b1;
    assign w_ridx = paddr[4:2];
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.org_x <= '0;
            r_cfg.org_y <= '0;
            r_cfg.org_z <= '0;
            r_cfg.dir_x <= '0;
            r_cfg.dir_y <= rtnf_pkg::DATA_W'(1) << FRAC_BITS;
            r_cfg.dir_z <= '0;
            r_cfg.eps   <= rtnf_pkg::EPS_W'(1);
        end else if (w_wr) begin
            unique case (w_ridx)
                rtnf_pkg::REG_ORG_X: r_cfg.org_x <= pwdata;
                rtnf_pkg::REG_ORG_Y: r_cfg.org_y <= pwdata;
                rtnf_pkg::REG_ORG_Z: r_cfg.org_z <= pwdata;
                rtnf_pkg::REG_DIR_X: r_cfg.dir_x <= pwdata;
                rtnf_pkg::REG_DIR_Y: r_cfg.dir_y <= pwdata;
                rtnf_pkg::REG_DIR_Z: r_cfg.dir_z <= pwdata;
                rtnf_pkg::REG_EPS:   r_cfg.eps   <= pwdata[rtnf_pkg::EPS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_ridx)
            rtnf_pkg::REG_ORG_X: prdata = r_cfg.org_x;
            rtnf_pkg::REG_ORG_Y: prdata = r_cfg.org_y;
            rtnf_pkg::REG_ORG_Z: prdata = r_cfg.org_z;
            rtnf_pkg::REG_DIR_X: prdata = r_cfg.dir_x;
            rtnf_pkg::REG_DIR_Y: prdata = r_cfg.dir_y;
            rtnf_pkg::REG_DIR_Z: prdata = r_cfg.dir_z;
            rtnf_pkg::REG_EPS:   prdata = rtnf_pkg::DATA_W'(r_cfg.eps);
            default:             prdata = '0;
        endcase
    end

    rtnf_ctrl #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_tri.valid),
        .o_in_ready  (i_tri.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    rtnf_dp #(
        .MAX_TRIANGLES (MAX_TRIANGLES),
        .FRAC_BITS     (FRAC_BITS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_tri   (i_tri.payload),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts),
        .o_res   (o_res.payload)
    );

endmodule
